### rtl/pbr_mix_pkg.sv
// types, constants and helpers shared by the channel mixer modules
// no dependencies; imported by every rtl file of the block
package pbr_mix_pkg;

	localparam int PIXEL_WORDS    = 10;
	localparam int NUM_SLOTS_DEF  = 10;
	localparam int MAX_COMPONENTS = 4;
	localparam int NUM_OUT_CHAN   = 4;
	localparam int NUM_CHAN_CODES = 6;
	localparam int APB_ADDR_W     = 6;
	localparam int APB_DATA_W     = 64;
	localparam int RULE_W         = 37;
	localparam int SRC_COUNTS_W   = 20;

	localparam logic [7:0]  LUMA_R     = 8'd54;
	localparam logic [7:0]  LUMA_G     = 8'd183;
	localparam logic [7:0]  LUMA_B     = 8'd19;
	localparam logic [7:0]  FULL_BYTE  = 8'd255;
	localparam logic [15:0] ROUND_BIAS = 16'd127;

	localparam logic [RULE_W-1:0]       RULE_RESET       = 37'h0FF80001FF;
	localparam logic [2:0]              OUT_COUNT_RESET  = 3'd4;
	localparam logic [SRC_COUNTS_W-1:0] SRC_COUNTS_RESET = 20'hFFFFF;

	typedef enum logic [2:0] {
		REG_RULE0,
		REG_RULE1,
		REG_RULE2,
		REG_RULE3,
		REG_OUT_COUNT,
		REG_SRC_COUNTS
	} reg_index_t;

	typedef enum logic [2:0] {
		CH_RED,
		CH_GREEN,
		CH_BLUE,
		CH_ALPHA,
		CH_LUMA,
		CH_MAX
	} chan_code_t;

	typedef enum logic {
		OP_COPY,
		OP_LERP
	} mix_op_t;

	// constant flag, then byte or {invert, channel code, slot}
	typedef struct packed {
		logic       is_const;
		logic [7:0] val;
	} operand_field_t;

	typedef struct packed {
		mix_op_t        op;
		operand_field_t scale;
		operand_field_t t;
		operand_field_t b;
		operand_field_t a;
	} chan_rule_t;

	// per-slot channel bytes, indexed by channel code
	typedef logic [NUM_CHAN_CODES-1:0][7:0] slot_chan_t;

	typedef struct packed {
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] t;
		logic [7:0] s;
	} lane_ops_t;

	typedef struct packed {
		logic [31:0] environment_pixel;
		logic [31:0] specular_tint_pixel;
		logic [31:0] glossiness_pixel;
		logic [31:0] opacity_pixel;
		logic [31:0] normal_pixel;
		logic [31:0] metallic_pixel;
		logic [31:0] roughness_pixel;
		logic [31:0] occlusion_pixel;
		logic [31:0] emissive_pixel;
		logic [31:0] base_color_pixel;
	} mix_in_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [7:0] out_alpha;
	} mix_out_t;

	// x / 255 rounded down, for x below 255*256, built from adds only
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] sum;
		sum = {1'b0, x} + 17'(x[15:8]) + 17'd1;
		return sum[15:8];
	endfunction

endpackage

### rtl/pbr_mix_slot_stage.sv
// stage 1: per-slot channel bytes (components, luma, max-rgb)
// depends on pbr_mix_pkg
module pbr_mix_slot_stage
	import pbr_mix_pkg::*;
#(
	parameter int SLOTS = NUM_SLOTS_DEF
) (
	input  logic                               clk,
	input  logic                               en,
	input  logic [PIXEL_WORDS-1:0][31:0]       words,
	input  logic [SRC_COUNTS_W-1:0]            src_counts,
	output slot_chan_t [SLOTS-1:0]             chan_s1
);

	function automatic slot_chan_t derive_slot(input logic [31:0] word,
			input logic [1:0] cnt_m1);
		logic [7:0]  c0;
		logic [7:0]  c1;
		logic [7:0]  c2;
		logic [7:0]  c3;
		logic [2:0]  comps;
		logic [15:0] luma_sum;
		logic [7:0]  mx;
		slot_chan_t  r;
		c0 = word[7:0];
		c1 = word[15:8];
		c2 = word[23:16];
		c3 = word[31:24];
		comps = 3'(cnt_m1) + 3'd1;
		if (comps > 3'(MAX_COMPONENTS)) begin
			comps = 3'(MAX_COMPONENTS);
		end
		luma_sum = 16'(c0) * 16'(LUMA_R) + 16'(c1) * 16'(LUMA_G)
			+ 16'(c2) * 16'(LUMA_B);
		mx = c0;
		if (c1 > mx) begin
			mx = c1;
		end
		if (c2 > mx) begin
			mx = c2;
		end
		r = '0;
		r[CH_RED]   = c0;
		r[CH_GREEN] = (comps > 3'd1) ? c1 : c0;
		r[CH_BLUE]  = (comps > 3'd2) ? c2 : c0;
		r[CH_ALPHA] = (comps > 3'd3) ? c3 : FULL_BYTE;
		r[CH_LUMA]  = (comps < 3'd3) ? c0 : luma_sum[15:8];
		r[CH_MAX]   = (comps < 3'd3) ? c0 : mx;
		return r;
	endfunction

	slot_chan_t [SLOTS-1:0] chan_d;

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			chan_d[i] = derive_slot(words[i], src_counts[2*i +: 2]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			chan_s1 <= chan_d;
		end
	end

endmodule

### rtl/pbr_mix_operand_stage.sv
// stage 2: operand select for the four output channels
// depends on pbr_mix_pkg
module pbr_mix_operand_stage
	import pbr_mix_pkg::*;
#(
	parameter int SLOTS = NUM_SLOTS_DEF
) (
	input  logic                               clk,
	input  logic                               en,
	input  slot_chan_t [SLOTS-1:0]             chan_s1,
	input  chan_rule_t [NUM_OUT_CHAN-1:0]      rules,
	output lane_ops_t  [NUM_OUT_CHAN-1:0]      ops_s2
);

	function automatic logic [7:0] pick(input operand_field_t f,
			input slot_chan_t [SLOTS-1:0] ch);
		logic [3:0] slot;
		chan_code_t code;
		slot_chan_t sel;
		logic [7:0] v;
		slot = f.val[3:0];
		code = chan_code_t'(f.val[6:4]);
		sel  = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (slot == 4'(i)) begin
				sel = ch[i];
			end
		end
		case (code)
			CH_GREEN: v = sel[CH_GREEN];
			CH_BLUE:  v = sel[CH_BLUE];
			CH_ALPHA: v = sel[CH_ALPHA];
			CH_LUMA:  v = sel[CH_LUMA];
			CH_MAX:   v = sel[CH_MAX];
			default:  v = sel[CH_RED];
		endcase
		if (f.val[7]) begin
			v = FULL_BYTE - v;
		end
		if (f.is_const) begin
			v = f.val;
		end else if ({1'b0, slot} >= 5'(SLOTS)) begin
			v = FULL_BYTE;
		end
		return v;
	endfunction

	lane_ops_t [NUM_OUT_CHAN-1:0] ops_d;

	always_comb begin
		for (int c = 0; c < NUM_OUT_CHAN; c++) begin
			ops_d[c].a = pick(rules[c].a, chan_s1);
			ops_d[c].b = pick(rules[c].b, chan_s1);
			// copy is a lerp with t = 0
			ops_d[c].t = (rules[c].op == OP_LERP) ? pick(rules[c].t, chan_s1) : 8'd0;
			ops_d[c].s = pick(rules[c].scale, chan_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ops_s2 <= ops_d;
		end
	end

endmodule

### rtl/pbr_mix_blend_lane.sv
// stages 3 to 6 of one output channel: lerp, divide, scale, divide
// depends on pbr_mix_pkg
module pbr_mix_blend_lane
	import pbr_mix_pkg::*;
(
	input  logic       clk,
	input  logic       en,
	input  lane_ops_t  ops_s2,
	input  logic       active,
	output logic [7:0] out_s6
);

	logic [15:0] x_s3;
	logic [7:0]  s_s3;
	logic [7:0]  v_s4;
	logic [7:0]  s_s4;
	logic [15:0] y_s5;
	logic [7:0]  nt;

	assign nt = FULL_BYTE - ops_s2.t;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s3   <= 16'(ops_s2.a) * 16'(nt) + 16'(ops_s2.b) * 16'(ops_s2.t) + ROUND_BIAS;
			s_s3   <= ops_s2.s;
			v_s4   <= div255(x_s3);
			s_s4   <= s_s3;
			y_s5   <= 16'(v_s4) * 16'(s_s4) + ROUND_BIAS;
			out_s6 <= active ? div255(y_s5) : 8'd0;
		end
	end

endmodule

### rtl/pbr_texture_channel_mixer.sv
// top level of the per-pixel texture channel mixer
// depends on pbr_mix_pkg, pbr_mix_slot_stage, pbr_mix_operand_stage, pbr_mix_blend_lane
//
// usage:
//   pix channel (pix_valid/pix_ready/pix_data) carries one pixel position per item:
//   one rgba word for each of the ten source slots
//   mix channel (mix_valid/mix_ready/mix_data) returns one item of four output bytes
//   apb port sets the four channel rules, output channel count and slot counts;
//   registers sit at byte addresses 0, 8, ... 40, 64-bit data, pready always high
// pipeline: six register stages, s1 to s6; results are offered from the last one
// throughput: one item per cycle outside a stall; every stage advances together, the
//   luma and lerp/scale multipliers get a stage each, divide by 255 is adds
// reset: all stage valid bits clear, registers return to copy of 255 on every
//   channel, four output channels and four components per slot
// stall: while mix_valid is high and mix_ready low the whole pipe holds and
//   pix_ready is low; no item is dropped or repeated
module pbr_texture_channel_mixer
	import pbr_mix_pkg::*;
#(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pix_valid,
	output logic                  pix_ready,
	input  mix_in_t               pix_data,
	output logic                  mix_valid,
	input  logic                  mix_ready,
	output mix_out_t              mix_data,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	// slots beyond the ten input words always read as 255
	localparam int USED_SLOTS = (NUM_SLOTS < PIXEL_WORDS) ? NUM_SLOTS : PIXEL_WORDS;

	// configuration registers
	chan_rule_t [NUM_OUT_CHAN-1:0] rule_q;
	logic [2:0]                    out_count_q;
	logic [SRC_COUNTS_W-1:0]       src_counts_q;

	reg_index_t reg_idx;
	logic       wr_en;

	assign pready  = 1'b1;
	assign reg_idx = reg_index_t'(paddr[APB_ADDR_W-1:3]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_OUT_CHAN; c++) begin
				rule_q[c] <= chan_rule_t'(RULE_RESET);
			end
			out_count_q  <= OUT_COUNT_RESET;
			src_counts_q <= SRC_COUNTS_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_RULE0:      rule_q[0] <= chan_rule_t'(pwdata[RULE_W-1:0]);
				REG_RULE1:      rule_q[1] <= chan_rule_t'(pwdata[RULE_W-1:0]);
				REG_RULE2:      rule_q[2] <= chan_rule_t'(pwdata[RULE_W-1:0]);
				REG_RULE3:      rule_q[3] <= chan_rule_t'(pwdata[RULE_W-1:0]);
				REG_OUT_COUNT:  out_count_q <= pwdata[2:0];
				REG_SRC_COUNTS: src_counts_q <= pwdata[SRC_COUNTS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_RULE0:      prdata = APB_DATA_W'(rule_q[0]);
			REG_RULE1:      prdata = APB_DATA_W'(rule_q[1]);
			REG_RULE2:      prdata = APB_DATA_W'(rule_q[2]);
			REG_RULE3:      prdata = APB_DATA_W'(rule_q[3]);
			REG_OUT_COUNT:  prdata = APB_DATA_W'(out_count_q);
			REG_SRC_COUNTS: prdata = APB_DATA_W'(src_counts_q);
			default:        prdata = '0;
		endcase
	end

	// count of 0 acts as 1, anything above 4 as 4
	logic [2:0]              eff_count;
	logic [NUM_OUT_CHAN-1:0] chan_active;

	always_comb begin
		if (out_count_q == 3'd0) begin
			eff_count = 3'd1;
		end else if (out_count_q > 3'(NUM_OUT_CHAN)) begin
			eff_count = 3'(NUM_OUT_CHAN);
		end else begin
			eff_count = out_count_q;
		end
		for (int c = 0; c < NUM_OUT_CHAN; c++) begin
			chan_active[c] = 3'(c) < eff_count;
		end
	end

	// pipeline control: one advance strobe for all stages
	logic adv;
	logic v_s1;
	logic v_s2;
	logic v_s3;
	logic v_s4;
	logic v_s5;
	logic v_s6;

	assign adv       = !v_s6 || mix_ready;
	assign pix_ready = adv;
	assign mix_valid = v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pix_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// slot words, slot 0 in the lowest lane
	logic [PIXEL_WORDS-1:0][31:0] words;

	assign words = {pix_data.environment_pixel, pix_data.specular_tint_pixel,
		pix_data.glossiness_pixel, pix_data.opacity_pixel, pix_data.normal_pixel,
		pix_data.metallic_pixel, pix_data.roughness_pixel, pix_data.occlusion_pixel,
		pix_data.emissive_pixel, pix_data.base_color_pixel};

	slot_chan_t [USED_SLOTS-1:0]  chan_s1;
	lane_ops_t [NUM_OUT_CHAN-1:0] ops_s2;
	logic [NUM_OUT_CHAN-1:0][7:0] out_s6;

	pbr_mix_slot_stage #(
		.SLOTS(USED_SLOTS)
	) u_slot (
		.clk        (clk),
		.en         (adv),
		.words      (words),
		.src_counts (src_counts_q),
		.chan_s1    (chan_s1)
	);

	pbr_mix_operand_stage #(
		.SLOTS(USED_SLOTS)
	) u_operand (
		.clk     (clk),
		.en      (adv),
		.chan_s1 (chan_s1),
		.rules   (rule_q),
		.ops_s2  (ops_s2)
	);

	for (genvar c = 0; c < NUM_OUT_CHAN; c++) begin : g_lane
		pbr_mix_blend_lane u_lane (
			.clk    (clk),
			.en     (adv),
			.ops_s2 (ops_s2[c]),
			.active (chan_active[c]),
			.out_s6 (out_s6[c])
		);
	end

	assign mix_data.out_red   = out_s6[0];
	assign mix_data.out_green = out_s6[1];
	assign mix_data.out_blue  = out_s6[2];
	assign mix_data.out_alpha = out_s6[3];

`ifndef SYNTH
	// an accepted item always lands in the first stage
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid && pix_ready) |=> v_s1)
		else $error("accepted item missing from first stage");

	// a stalled result freezes every stage valid bit
	a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s6 && !mix_ready) |=> (v_s6 && $stable({v_s1, v_s2, v_s3, v_s4, v_s5})))
		else $error("pipeline moved during output stall");

	// the alpha channel reads zero when it lies past the output count
	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(mix_valid && !chan_active[3]) |-> (mix_data.out_alpha == 8'd0))
		else $error("unused alpha channel not zero");
`endif

endmodule
